[hdl/swr_pkg.sv]
// Package for the sequence window repeat filter: field widths, register
// indexes, reset values and the command/status types between controller and datapath.
// No dependencies.
package swr_pkg;

    // Field widths
    localparam int SYM_W      = 8;
    localparam int TAG_W      = 16;
    localparam int POS_W      = 17;
    localparam int WL_W       = 6;
    localparam int LIM_W      = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_LIMIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT  = 2'd3;

    // Register reset values
    localparam logic [WL_W-1:0]  RST_WINDOW_LENGTH = 6'd27;
    localparam logic [WL_W-1:0]  RST_MIN_LENGTH    = 6'd26;
    localparam logic [LIM_W-1:0] RST_RUN_LIMIT     = 5'd3;
    localparam logic [LIM_W-1:0] RST_REPEAT_LIMIT  = 5'd5;

    // Parameter defaults
    localparam int              DEF_MAX_WINDOW  = 32;
    localparam longint unsigned DEF_MAX_SEQ_LEN = 64'd65536;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic rd;       // issue next window read
        logic load;     // load the result into the output register
    } t_swr_cmd;

    // Datapath to controller
    typedef struct packed {
        logic emit;     // the offered character completes a window
        logic rd_last;  // the read being issued is the last of the window
        logic out_free; // output register can take a result this cycle
    } t_swr_sts;

endpackage

[hdl/swr_if.sv]
// Stream interfaces for the input characters and the window results.
// Depends on swr_pkg.
interface swr_in_if;
    import swr_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             first_of_sequence;
    logic [TAG_W-1:0] sequence_tag;

    modport source (output valid, output symbol, output first_of_sequence,
                    output sequence_tag, input ready);
    modport sink   (input valid, input symbol, input first_of_sequence,
                    input sequence_tag, output ready);
endinterface

interface swr_out_if;
    import swr_pkg::*;

    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] result_tag;
    logic [POS_W-1:0] window_start;
    logic [POS_W-1:0] window_end;
    logic             misprime;

    modport source (output valid, output result_tag, output window_start,
                    output window_end, output misprime, input ready);
    modport sink   (input valid, input result_tag, input window_start,
                    input window_end, input misprime, output ready);
endinterface

[hdl/swr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/swr_ctrl.sv]
// Controller for the sequence window repeat filter: steps each window scan.
// Depends on swr_pkg.
module swr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  swr_pkg::t_swr_sts i_sts,
    output swr_pkg::t_swr_cmd o_cmd
);
    import swr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a character
    localparam logic [1:0] S_SCAN = 2'd1;  // reading window characters
    localparam logic [1:0] S_LAST = 2'd2;  // last character in flight
    localparam logic [1:0] S_DONE = 2'd3;  // flag final, hand over result

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands; no beat is taken while reset is held
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
                if (i_in_valid && i_sts.emit) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.rd_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[hdl/swr_dp.sv]
// Datapath for the sequence window repeat filter: registers, window store,
// position counter, run/repeat scan and output register.
// Depends on swr_pkg and swr_ram.
module swr_dp #(
    parameter int              MAX_WINDOW  = swr_pkg::DEF_MAX_WINDOW,
    parameter longint unsigned MAX_SEQ_LEN = swr_pkg::DEF_MAX_SEQ_LEN
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [swr_pkg::SYM_W-1:0]        i_symbol,
    input  logic                             i_first,
    input  logic [swr_pkg::TAG_W-1:0]        i_tag,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [swr_pkg::TAG_W-1:0]        o_result_tag,
    output logic [swr_pkg::POS_W-1:0]        o_window_start,
    output logic [swr_pkg::POS_W-1:0]        o_window_end,
    output logic                             o_misprime,
    input  swr_pkg::t_swr_cmd                i_cmd,
    output swr_pkg::t_swr_sts                o_sts
);
    import swr_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_SEQ_LEN + 64'd1);
    localparam int XW = WL_W + 1;

    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [XW-1:0] MW_X     = XW'(MAX_WINDOW);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_SEQ_LEN);

    // Configuration registers
    logic [WL_W-1:0]  r_wl;
    logic [WL_W-1:0]  r_min;
    logic [LIM_W-1:0] r_run_lim;
    logic [LIM_W-1:0] r_rep_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl      <= RST_WINDOW_LENGTH;
            r_min     <= RST_MIN_LENGTH;
            r_run_lim <= RST_RUN_LIMIT;
            r_rep_lim <= RST_REPEAT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_LENGTH: r_wl      <= i_cfg_data;
                CFG_MIN_LENGTH:    r_min     <= i_cfg_data;
                CFG_RUN_LIMIT:     r_run_lim <= i_cfg_data[LIM_W-1:0];
                CFG_REPEAT_LIMIT:  r_rep_lim <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence position and write pointer
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wp;
    logic [CW-1:0] cnt_base;
    logic [CW-1:0] n_cnt;
    logic          wl_ok;
    logic [XW-1:0] start_sum;
    logic [XW-1:0] start_idx;

    always_comb begin
        cnt_base  = i_first ? '0 : r_cnt;
        n_cnt     = (cnt_base < CNT_MAX) ? cnt_base + CW'(1) : cnt_base;
        n_wp      = (r_wp == PTR_LAST) ? '0 : r_wp + AW'(1);
        wl_ok     = (r_wl != '0) && (XW'(r_wl) <= MW_X) && (r_wl >= r_min);
        // oldest window character, modulo the store depth
        start_sum = XW'(n_wp) + MW_X - XW'(r_wl);
        start_idx = (start_sum >= MW_X) ? start_sum - MW_X : start_sum;
    end

    assign o_sts.emit = wl_ok && (n_cnt >= CW'(r_wl));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_wp  <= n_wp;
            r_cnt <= n_cnt;
        end
    end

    // Window store
    logic [AW-1:0]    r_ra;
    logic [SYM_W-1:0] rd_data;

    swr_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_WINDOW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (r_wp),
        .i_wdata (i_symbol),
        .i_raddr (r_ra),
        .o_rdata (rd_data)
    );

    // Read sequencing over the window
    logic [XW-1:0] r_rd_k;
    logic          r_rd_v;

    assign o_sts.rd_last = (r_rd_k + XW'(1)) == XW'(r_wl);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ra   <= AW'(start_idx);
            r_rd_k <= '0;
        end else if (i_cmd.rd) begin
            r_ra   <= (r_ra == PTR_LAST) ? '0 : r_ra + AW'(1);
            r_rd_k <= r_rd_k + XW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd;
        end
    end

    // Run and dinucleotide repeat scan, one character a cycle
    logic [SYM_W-1:0] r_h1, r_h2, r_h3;
    logic [1:0]       r_seen;
    logic [RW-1:0]    r_runs;
    logic [RW-1:0]    r_reps;
    logic             r_flag;
    logic             run_hit;
    logic             rep_hit;
    logic [XW-1:0]    runs_inc;
    logic [XW-1:0]    reps_inc;

    always_comb begin
        run_hit  = (r_seen != 2'd0) && (rd_data == r_h1);
        rep_hit  = (rd_data == r_h2) && (r_h1 == r_h3);
        runs_inc = XW'(r_runs) + XW'(1);
        reps_inc = XW'(r_reps) + XW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seen <= '0;
            r_runs <= '0;
            r_reps <= '0;
            r_flag <= 1'b0;
        end else if (r_rd_v) begin
            r_h1 <= rd_data;
            r_h2 <= r_h1;
            r_h3 <= r_h2;
            if (r_seen != 2'd3) begin
                r_seen <= r_seen + 2'd1;
            end
            if (run_hit) begin
                r_runs <= RW'(runs_inc);
                if (runs_inc > XW'(r_run_lim)) begin
                    r_flag <= 1'b1;
                end
            end else begin
                r_runs <= '0;
            end
            // repeats only counted from the fourth character on
            if (r_seen == 2'd3) begin
                if (rep_hit) begin
                    r_reps <= RW'(reps_inc);
                    if (reps_inc > XW'(r_rep_lim)) begin
                        r_flag <= 1'b1;
                    end
                end else begin
                    r_reps <= '0;
                end
            end
        end
    end

    // Result fields captured at accept
    logic [TAG_W-1:0] r_tag;
    logic [CW-1:0]    r_end;
    logic [CW-1:0]    r_start;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag   <= i_tag;
            r_end   <= n_cnt;
            r_start <= n_cnt - CW'(r_wl) + CW'(1);
        end
    end

    // Output register
    logic             r_out_v;
    logic [TAG_W-1:0] r_o_tag;
    logic [POS_W-1:0] r_o_start;
    logic [POS_W-1:0] r_o_end;
    logic             r_o_mis;

    assign o_sts.out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_tag   <= r_tag;
            r_o_start <= POS_W'(r_start);
            r_o_end   <= POS_W'(r_end);
            r_o_mis   <= r_flag;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_result_tag   = r_o_tag;
    assign o_window_start = r_o_start;
    assign o_window_end   = r_o_end;
    assign o_misprime     = r_o_mis;
endmodule

[hdl/sequence_window_repeat_filter_unit.sv]
// Sequence window repeat filter, top level: controller and datapath.
// A character that completes no window is taken and the input stays ready.
// A character that completes a window of window_length characters holds
// the input off while its window is scanned and then while the previous
// result still waits in the output register: the window store has one
// read port and the scan reads one character a cycle from it. The store
// needs no clearing after reset. Position fields saturate at MAX_SEQ_LEN.
// Depends on swr_pkg, swr_if, swr_ctrl and swr_dp.
module sequence_window_repeat_filter_unit #(
    parameter int              MAX_WINDOW  = swr_pkg::DEF_MAX_WINDOW,
    parameter longint unsigned MAX_SEQ_LEN = swr_pkg::DEF_MAX_SEQ_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [swr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    swr_in_if.sink                         i_in,
    swr_out_if.source                      o_out
);
    import swr_pkg::*;

    t_swr_cmd cmd;
    t_swr_sts sts;

    // Sequencing
    swr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Storage, counting and scan
    swr_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_SEQ_LEN (MAX_SEQ_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_symbol       (i_in.symbol),
        .i_first        (i_in.first_of_sequence),
        .i_tag          (i_in.sequence_tag),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_result_tag   (o_out.result_tag),
        .o_window_start (o_out.window_start),
        .o_window_end   (o_out.window_end),
        .o_misprime     (o_out.misprime),
        .i_cmd          (cmd),
        .o_sts          (sts)
    );
endmodule

[hdl/swr_checker.sv]
// Port-level checks for the sequence window repeat filter, bound to the top level.
// Depends on swr_pkg and sequence_window_repeat_filter_unit.
module swr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [swr_pkg::TAG_W-1:0]   i_result_tag,
    input logic [swr_pkg::POS_W-1:0]   i_window_start,
    input logic [swr_pkg::POS_W-1:0]   i_window_end,
    input logic                        i_misprime
);
    import swr_pkg::*;

    // A stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_result_tag) && $stable(i_window_start)
            && $stable(i_window_end) && $stable(i_misprime))
        else $error("result payload changed while stalled");

    // A window never ends before it starts, and starts at one or later
    a_window_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_window_end >= i_window_start) && (i_window_start != '0))
        else $error("window positions out of order");

    // A new result appears only after a scan, which holds the input off
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result raised without a window scan");
endmodule

bind sequence_window_repeat_filter_unit swr_checker u_swr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_tag   (o_out.result_tag),
    .i_window_start (o_out.window_start),
    .i_window_end   (o_out.window_end),
    .i_misprime     (o_out.misprime)
);
